FILE: hdl/mnta_pkg.sv
`timescale 1ns / 1ps

package mnta_pkg;

	// identifier space of the message fields
	localparam int ID_SPACE = 16;
	localparam int ID_W = 4;
	localparam int CLK_W = 16;

	// default for the node count limit
	localparam int MAX_NODES_DEF = 16;

	// register reset values and saturation limits
	localparam logic [3:0] NODE_ID_RST = 4'd0;
	localparam logic [4:0] NODE_COUNT_RST = 5'd3;
	localparam logic [15:0] INIT_CLOCK_RST = 16'd1;
	localparam logic [7:0] ENTRY_LIMIT_RST = 8'd5;
	localparam logic [15:0] CLOCK_MAX = 16'hFFFF;
	localparam logic [7:0] ENTRY_MAX = 8'hFF;
	localparam logic [3:0] REPLY_MAX = 4'hF;

	typedef enum logic [1:0] {
		CFG_NODE_ID     = 2'd0,
		CFG_NODE_COUNT  = 2'd1,
		CFG_INIT_CLOCK  = 2'd2,
		CFG_ENTRY_LIMIT = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_REQ   = 2'd1,
		KIND_RESP  = 2'd2,
		KIND_LEAVE = 2'd3
	} in_kind_t;

	typedef enum logic [1:0] {
		OUT_REQ   = 2'd0,
		OUT_RESP  = 2'd1,
		OUT_GRANT = 2'd2
	} out_kind_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_REQ  = 2'd1,
		PH_CS   = 2'd2
	} phase_t;

	// outcome of one item, decided by the datapath
	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_RESP  = 2'd1,
		ACT_GRANT = 2'd2,
		ACT_WALK  = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		OSEL_RESP  = 2'd0,
		OSEL_GRANT = 2'd1,
		OSEL_WALK  = 2'd2
	} osel_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_EXEC  = 3'd1,
		ST_RESP  = 3'd2,
		ST_GRANT = 3'd3,
		ST_WALK  = 3'd4
	} state_t;

	typedef struct packed {
		logic  load_in;
		logic  exec;
		logic  out_load;
		osel_t out_sel;
		logic  walk_pop;
	} cmd_t;

	typedef struct packed {
		act_t act;
		logic out_free;
		logic pend_empty;
		logic walk_last;
	} stat_t;

	// index of the lowest set bit
	function automatic logic [ID_W-1:0] lowest_bit(input logic [ID_SPACE-1:0] v);
		logic [ID_W-1:0] r;
		r = '0;
		for (int i = ID_SPACE - 1; i >= 0; i--) begin
			if (v[i]) r = ID_W'(i);
		end
		return r;
	endfunction

endpackage

FILE: hdl/mnta_ctrl.sv
`timescale 1ns / 1ps

module mnta_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  mnta_pkg::stat_t  stat,
	output mnta_pkg::cmd_t   cmd
);

	mnta_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mnta_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		cmd = '0;
		cmd.out_sel = mnta_pkg::OSEL_RESP;
		case (state_q)
			mnta_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = mnta_pkg::ST_EXEC;
				end
			end
			mnta_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				case (stat.act)
					mnta_pkg::ACT_RESP:  state_d = mnta_pkg::ST_RESP;
					mnta_pkg::ACT_GRANT: state_d = mnta_pkg::ST_GRANT;
					mnta_pkg::ACT_WALK:  state_d = mnta_pkg::ST_WALK;
					default:             state_d = mnta_pkg::ST_IDLE;
				endcase
			end
			mnta_pkg::ST_RESP: begin
				cmd.out_sel = mnta_pkg::OSEL_RESP;
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = mnta_pkg::ST_IDLE;
				end
			end
			mnta_pkg::ST_GRANT: begin
				cmd.out_sel = mnta_pkg::OSEL_GRANT;
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = mnta_pkg::ST_IDLE;
				end
			end
			mnta_pkg::ST_WALK: begin
				cmd.out_sel = mnta_pkg::OSEL_WALK;
				if (stat.pend_empty) begin
					state_d = mnta_pkg::ST_IDLE;
				end else if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.walk_pop = 1'b1;
					if (stat.walk_last) state_d = mnta_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mnta_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hdl/mnta_dp.sv
`timescale 1ns / 1ps

module mnta_dp #(
	parameter int MAX_NODES = mnta_pkg::MAX_NODES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [1:0]       cfg_idx,
	input  logic [15:0]      cfg_wdata,
	input  logic [1:0]       kind,
	input  logic [3:0]       sender_id,
	input  logic [15:0]      sender_clock,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       out_kind,
	output logic [3:0]       dest_id,
	output logic [15:0]      msg_clock,
	output logic             last,
	input  mnta_pkg::cmd_t   cmd,
	output mnta_pkg::stat_t  stat
);

	localparam int NLIM = (MAX_NODES < mnta_pkg::ID_SPACE) ? MAX_NODES : mnta_pkg::ID_SPACE;
	localparam int IDS = mnta_pkg::ID_SPACE;

	// configuration
	logic [3:0]  node_id_q;
	logic [4:0]  node_count_q;
	logic [7:0]  entry_limit_q;

	// node state
	logic [15:0]       local_clock_q;
	logic [15:0]       req_stamp_q;
	logic              wants_q;
	logic [3:0]        reply_q;
	logic [7:0]        entry_q;
	mnta_pkg::phase_t  phase_q;
	logic [IDS-1:0]    def_valid_q;
	logic [15:0]       def_stamp_q [IDS];
	logic [IDS-1:0]    pend_q;

	// latched item
	mnta_pkg::in_kind_t kind_q;
	logic [3:0]         sid_q;
	logic [15:0]        sclk_q;

	// output register
	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [3:0]  dest_q;
	logic [15:0] msg_clock_q;
	logic        last_q;

	logic [4:0]     n_eff;
	logic [4:0]     others;
	logic           valid_sender;
	logic [15:0]    clk_max;
	logic [15:0]    clk_adv;
	logic [3:0]     reply_nxt;
	logic [7:0]     entry_nxt;
	logic           defer;
	logic [IDS-1:0] self_mask;
	logic [IDS-1:0] below_n;
	logic [3:0]     walk_idx;
	logic           walk_last;
	logic           out_free;
	mnta_pkg::act_t act;

	assign n_eff = (node_count_q > 5'(NLIM)) ? 5'(NLIM) : node_count_q;
	assign others = ({1'b0, node_id_q} < n_eff) ? n_eff - 5'd1 : n_eff;
	assign valid_sender = ({1'b0, sid_q} < n_eff) && (sid_q != node_id_q);
	assign clk_max = (local_clock_q > sclk_q) ? local_clock_q : sclk_q;
	assign clk_adv = (clk_max == mnta_pkg::CLOCK_MAX) ? mnta_pkg::CLOCK_MAX : clk_max + 16'd1;
	assign reply_nxt = (reply_q == mnta_pkg::REPLY_MAX) ? mnta_pkg::REPLY_MAX : reply_q + 4'd1;
	assign entry_nxt = (entry_q == mnta_pkg::ENTRY_MAX) ? mnta_pkg::ENTRY_MAX : entry_q + 8'd1;
	assign self_mask = IDS'(1) << node_id_q;

	always_comb begin
		for (int i = 0; i < IDS; i++) begin
			below_n[i] = 5'(i) < n_eff;
		end
	end

	// in the critical section every request is deferred; while requesting, lower stamp wins, then lower id
	always_comb begin
		case (phase_q)
			mnta_pkg::PH_CS:  defer = 1'b1;
			mnta_pkg::PH_REQ: defer = (req_stamp_q < sclk_q) ||
				((req_stamp_q == sclk_q) && (node_id_q < sid_q));
			default:          defer = 1'b0;
		endcase
	end

	always_comb begin
		act = mnta_pkg::ACT_NONE;
		case (kind_q)
			mnta_pkg::KIND_START: begin
				if (wants_q && phase_q == mnta_pkg::PH_IDLE)
					act = (others == 5'd0) ? mnta_pkg::ACT_GRANT : mnta_pkg::ACT_WALK;
			end
			mnta_pkg::KIND_REQ: begin
				if (valid_sender && !defer) act = mnta_pkg::ACT_RESP;
			end
			mnta_pkg::KIND_RESP: begin
				if (valid_sender && phase_q == mnta_pkg::PH_REQ &&
						{1'b0, reply_nxt} >= others)
					act = mnta_pkg::ACT_GRANT;
			end
			mnta_pkg::KIND_LEAVE: begin
				if (phase_q == mnta_pkg::PH_CS) act = mnta_pkg::ACT_WALK;
			end
			default: act = mnta_pkg::ACT_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q     <= mnta_pkg::NODE_ID_RST;
			node_count_q  <= mnta_pkg::NODE_COUNT_RST;
			entry_limit_q <= mnta_pkg::ENTRY_LIMIT_RST;
			local_clock_q <= mnta_pkg::INIT_CLOCK_RST;
			req_stamp_q   <= '0;
			wants_q       <= 1'b1;
			reply_q       <= '0;
			entry_q       <= '0;
			phase_q       <= mnta_pkg::PH_IDLE;
			def_valid_q   <= '0;
			pend_q        <= '0;
		end else begin
			if (cfg_wen) begin
				case (mnta_pkg::cfg_reg_t'(cfg_idx))
					mnta_pkg::CFG_NODE_ID:     node_id_q <= cfg_wdata[3:0];
					mnta_pkg::CFG_NODE_COUNT:  node_count_q <= cfg_wdata[4:0];
					mnta_pkg::CFG_INIT_CLOCK: begin
						local_clock_q <= cfg_wdata;
					end
					mnta_pkg::CFG_ENTRY_LIMIT: entry_limit_q <= cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (cmd.walk_pop) pend_q <= pend_q & ~(IDS'(1) << walk_idx);
			if (cmd.exec) begin
				case (kind_q)
					mnta_pkg::KIND_START: begin
						if (wants_q && phase_q == mnta_pkg::PH_IDLE) begin
							phase_q     <= (others == 5'd0) ? mnta_pkg::PH_CS : mnta_pkg::PH_REQ;
							req_stamp_q <= local_clock_q;
							reply_q     <= '0;
							pend_q      <= below_n & ~self_mask;
						end
					end
					mnta_pkg::KIND_REQ: begin
						if (valid_sender) begin
							local_clock_q <= clk_adv;
							if (defer) def_valid_q[sid_q] <= 1'b1;
						end
					end
					mnta_pkg::KIND_RESP: begin
						if (valid_sender) begin
							local_clock_q <= clk_adv;
							if (phase_q == mnta_pkg::PH_REQ) begin
								reply_q <= reply_nxt;
								if ({1'b0, reply_nxt} >= others) phase_q <= mnta_pkg::PH_CS;
							end
						end
					end
					mnta_pkg::KIND_LEAVE: begin
						if (phase_q == mnta_pkg::PH_CS) begin
							entry_q <= entry_nxt;
							if (entry_nxt >= entry_limit_q) wants_q <= 1'b0;
							phase_q     <= mnta_pkg::PH_IDLE;
							pend_q      <= def_valid_q & ~self_mask;
							def_valid_q <= '0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// deferred stamps, meaningful only under their valid bit
	always_ff @(posedge clk) begin
		if (cmd.exec && kind_q == mnta_pkg::KIND_REQ && valid_sender && defer)
			def_stamp_q[sid_q] <= sclk_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q <= mnta_pkg::in_kind_t'(kind);
			sid_q  <= sender_id;
			sclk_q <= sender_clock;
		end
	end

	// walk over pending ids, lowest first
	assign walk_idx = mnta_pkg::lowest_bit(pend_q);
	assign walk_last = (pend_q & ~(IDS'(1) << walk_idx)) == '0;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.out_sel)
				mnta_pkg::OSEL_GRANT: begin
					out_kind_q  <= mnta_pkg::OUT_GRANT;
					dest_q      <= node_id_q;
					msg_clock_q <= local_clock_q;
					last_q      <= 1'b1;
				end
				mnta_pkg::OSEL_WALK: begin
					if (kind_q == mnta_pkg::KIND_START) begin
						out_kind_q  <= mnta_pkg::OUT_REQ;
						msg_clock_q <= req_stamp_q;
					end else begin
						out_kind_q  <= mnta_pkg::OUT_RESP;
						msg_clock_q <= def_stamp_q[walk_idx];
					end
					dest_q <= walk_idx;
					last_q <= walk_last;
				end
				default: begin
					out_kind_q  <= mnta_pkg::OUT_RESP;
					dest_q      <= sid_q;
					msg_clock_q <= sclk_q;
					last_q      <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign dest_id   = dest_q;
	assign msg_clock = msg_clock_q;
	assign last      = last_q;

	assign stat.act        = act;
	assign stat.out_free   = out_free;
	assign stat.pend_empty = (pend_q == '0);
	assign stat.walk_last  = walk_last;

endmodule

FILE: hdl/mutex_node_timestamp_arbiter.sv
`timescale 1ns / 1ps

// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------
// cfg      | cfg_wen              | cfg_idx, cfg_wdata
// in       | in_valid / in_ready  | kind, sender_id, sender_clock
// out      | out_valid / out_ready| out_kind, dest_id, msg_clock, last
//
// one item at a time: taken, decided, then its results emitted in turn
// a start or leave walks pending ids: up to N results, N = min(node_count,
// MAX_NODES, 16); a start with no other node grants; ignored items and a
// bare leave give no result; reset restores node state, deferred valid bits
// and the output valid bit; a stalled output holds the walk in place; the
// next item may be taken while the last result sits in the output register

module mutex_node_timestamp_arbiter #(
	parameter int MAX_NODES = mnta_pkg::MAX_NODES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_wdata,
	// item input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [3:0]  sender_id,
	input  logic [15:0] sender_clock,
	// result output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_kind,
	output logic [3:0]  dest_id,
	output logic [15:0] msg_clock,
	output logic        last
);

	// command and status between sequencer and datapath
	mnta_pkg::cmd_t  cmd;
	mnta_pkg::stat_t stat;

	// sequencer: take, decide, emit
	mnta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// clock, counters, deferred table and output register
	mnta_dp #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.kind         (kind),
		.sender_id    (sender_id),
		.sender_clock (sender_clock),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_kind     (out_kind),
		.dest_id      (dest_id),
		.msg_clock    (msg_clock),
		.last         (last),
		.cmd          (cmd),
		.stat         (stat)
	);

`ifndef NO_ASSERTIONS
	// an item in transfer keeps the block busy the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while previous item still in work");

	// a grant is always the only and final result of its item
	a_grant_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_kind == mnta_pkg::OUT_GRANT) |-> last)
		else $error("grant not marked last");

	// no result kind outside request, response, grant
	a_out_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_kind == mnta_pkg::OUT_REQ || out_kind == mnta_pkg::OUT_RESP ||
			out_kind == mnta_pkg::OUT_GRANT))
		else $error("undefined result kind");

	// a result is only loaded while the output side can take it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("output register overwritten");
`endif

endmodule
